/* sv/mpt_pkg.sv */
`default_nettype none

package mpt_pkg;

  // default sizes
  localparam int MAX_LEVELS_DEF   = 4;
  localparam int TABLE_WORDS_DEF  = 65536;
  localparam int FRAME_BITS_DEF   = 20;
  localparam int ADDRESS_BITS_DEF = 32;

  // fixed field widths
  localparam int ADDR_W      = 32;
  localparam int FRAME_W     = 20;
  localparam int COUNT_W     = 32;
  localparam int ALIGN_W     = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 5;
  localparam int LVL_CNT_W   = 3;
  localparam int LVL_BITS_W  = 5;
  localparam int IDX_W       = 16;
  localparam int MAX_IDX_BITS = 16;

  // register reset values
  localparam logic [LVL_CNT_W-1:0]  LEVEL_COUNT_RST = 3'd2;
  localparam logic [LVL_BITS_W-1:0] BITS_L0_RST     = 5'd8;
  localparam logic [LVL_BITS_W-1:0] BITS_L1_RST     = 5'd8;
  localparam logic [LVL_BITS_W-1:0] BITS_L2_RST     = 5'd4;
  localparam logic [LVL_BITS_W-1:0] BITS_L3_RST     = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_COUNT = 3'd0,
    REG_BITS_L0     = 3'd1,
    REG_BITS_L1     = 3'd2,
    REG_BITS_L2     = 3'd3,
    REG_BITS_L3     = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_INSERT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_MISS     = 2'd0,
    STATUS_HIT      = 2'd1,
    STATUS_INSERTED = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic               func;
    logic [ADDR_W-1:0]  logical_address;
    logic [FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame_out;
    logic [COUNT_W-1:0] frames_allocated;
  } rsp_t;

  // flags from the step unit
  typedef struct packed {
    logic slot_ok;
    logic alloc_ok;
  } step_flags_t;

  // level width clamped to 1..16
  function automatic logic [LVL_BITS_W-1:0] eff_bits(input logic [LVL_BITS_W-1:0] b);
    logic [LVL_BITS_W-1:0] r;
    r = b;
    if (b == '0) begin
      r = LVL_BITS_W'(1);
    end else if (b > LVL_BITS_W'(MAX_IDX_BITS)) begin
      r = LVL_BITS_W'(MAX_IDX_BITS);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/multilevel_page_table.sv */
`default_nettype none

// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+----------------------------------
// req       | in        | req_valid_i/req_stall_o | req_i: func, address, frame
// rsp       | out       | rsp_valid_o/rsp_stall_i | rsp_o: status, frame, insert count
// cfg       | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a request walks each level it reaches in a read step and a check step, then posts
// the result from the done step and returns to idle; the next request is taken only
// from idle, so requests do not overlap; the single table memory port, one read per
// level and a write on insert, sets that pace
// after reset and after every write to a listed register the table is swept to zero,
// one entry a cycle; no request is taken meanwhile
// register writes are taken only while idle or sweeping, and hold off a request
// a finished result waits in the output register while the next request is taken;
// the walk holds before posting only if that register is still stalled

module multilevel_page_table #(
  parameter int MAX_LEVELS   = mpt_pkg::MAX_LEVELS_DEF,
  parameter int TABLE_WORDS  = mpt_pkg::TABLE_WORDS_DEF,
  parameter int FRAME_BITS   = mpt_pkg::FRAME_BITS_DEF,
  parameter int ADDRESS_BITS = mpt_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            req_valid_i,
  output logic                                 req_stall_o,
  input  wire mpt_pkg::req_t                   req_i,
  output logic                                 rsp_valid_o,
  input  wire logic                            rsp_stall_i,
  output mpt_pkg::rsp_t                        rsp_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mpt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mpt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // table and walk widths
  localparam int AW       = $clog2(TABLE_WORDS);
  localparam int SW       = ((AW > mpt_pkg::IDX_W) ? AW : mpt_pkg::IDX_W) + 1;
  localparam int NF_W     = ((AW > mpt_pkg::IDX_W + 1) ? AW : mpt_pkg::IDX_W + 1) + 1;
  localparam int PW       = (AW > FRAME_BITS) ? AW : FRAME_BITS;
  localparam int PX       = (PW > mpt_pkg::FRAME_W) ? PW : mpt_pkg::FRAME_W;
  localparam int FBE      = (FRAME_BITS < mpt_pkg::FRAME_W) ? FRAME_BITS : mpt_pkg::FRAME_W;
  localparam int LVL_CAP  = (MAX_LEVELS < 4) ? MAX_LEVELS : 4;
  localparam int ALIGN_SH = mpt_pkg::ALIGN_W - ADDRESS_BITS;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [mpt_pkg::LVL_CNT_W-1:0]  level_count_q, level_count_d;
  logic [mpt_pkg::LVL_BITS_W-1:0] bits_l0_q, bits_l0_d;
  logic [mpt_pkg::LVL_BITS_W-1:0] bits_l1_q, bits_l1_d;
  logic [mpt_pkg::LVL_BITS_W-1:0] bits_l2_q, bits_l2_d;
  logic [mpt_pkg::LVL_BITS_W-1:0] bits_l3_q, bits_l3_d;
  logic                           cfg_write;

  // control state
  logic [AW-1:0]                  clr_q, clr_d;
  logic [NF_W-1:0]                next_free_q, next_free_d;
  logic [mpt_pkg::COUNT_W-1:0]    insert_count_q, insert_count_d;
  logic [1:0]                     lvl_q, lvl_d;
  logic                           rsp_valid_q, rsp_valid_d;

  // walk payload
  logic [mpt_pkg::ALIGN_W-1:0]    aligned_q, aligned_d;
  logic [AW-1:0]                  base_q, base_d;
  logic [SW-1:0]                  slot_q, slot_d;
  logic                           insert_q, insert_d;
  logic [FBE-1:0]                 frame_q, frame_d;
  logic [1:0]                     status_q, status_d;
  logic [mpt_pkg::FRAME_W-1:0]    frame_out_q, frame_out_d;
  mpt_pkg::rsp_t                  rsp_q, rsp_d;

  // table memory
  logic [PW:0]                    mem [TABLE_WORDS];
  logic [PW:0]                    rd_q;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [PW:0]                    mem_wdata;
  logic                           mem_re;

  // level selection
  logic [mpt_pkg::LVL_BITS_W-1:0] cur_bits;
  logic [mpt_pkg::LVL_BITS_W-1:0] child_bits;
  logic [mpt_pkg::LVL_CNT_W-1:0]  eff_lc;
  logic [1:0]                     last_lvl;
  logic [1:0]                     lvl_next;

  // step unit
  logic [mpt_pkg::ALIGN_W-1:0]    su_aligned;
  logic [SW-1:0]                  su_slot;
  logic [NF_W-1:0]                su_next_free;
  mpt_pkg::step_flags_t           su_flags;

  logic                           req_accept;
  logic                           rsp_free;
  logic [PX-1:0]                  pay_ext;

  // writes only while no walk is in flight; a pending write holds off requests
  assign cfg_ready_o = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign req_stall_o = (state_q != ST_IDLE) || cfg_valid_i;
  assign req_accept  = req_valid_i && !req_stall_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign rsp_free    = !rsp_valid_q || !rsp_stall_i;
  assign lvl_next    = lvl_q + 2'd1;
  assign pay_ext     = PX'(rd_q[PW-1:0]);

  // effective level count, clamped to 1..cap
  always_comb begin
    eff_lc = level_count_q;
    if (level_count_q == '0) begin
      eff_lc = mpt_pkg::LVL_CNT_W'(1);
    end else if (level_count_q > mpt_pkg::LVL_CNT_W'(LVL_CAP)) begin
      eff_lc = mpt_pkg::LVL_CNT_W'(LVL_CAP);
    end
  end

  assign last_lvl = 2'(eff_lc - mpt_pkg::LVL_CNT_W'(1));

  // width of the level being walked and of the one below it
  always_comb begin
    unique case (lvl_q)
      2'd0: begin
        cur_bits   = mpt_pkg::eff_bits(bits_l0_q);
        child_bits = mpt_pkg::eff_bits(bits_l1_q);
      end
      2'd1: begin
        cur_bits   = mpt_pkg::eff_bits(bits_l1_q);
        child_bits = mpt_pkg::eff_bits(bits_l2_q);
      end
      2'd2: begin
        cur_bits   = mpt_pkg::eff_bits(bits_l2_q);
        child_bits = mpt_pkg::eff_bits(bits_l3_q);
      end
      default: begin
        cur_bits   = mpt_pkg::eff_bits(bits_l3_q);
        child_bits = mpt_pkg::eff_bits(bits_l0_q);
      end
    endcase
  end

  mpt_step_unit #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_step (
    .aligned_i   (aligned_q),
    .bits_i      (cur_bits),
    .base_i      (base_q),
    .next_free_i (next_free_q),
    .child_bits_i(child_bits),
    .aligned_o   (su_aligned),
    .slot_o      (su_slot),
    .next_free_o (su_next_free),
    .flags_o     (su_flags)
  );

  // register writes
  always_comb begin
    level_count_d = level_count_q;
    bits_l0_d     = bits_l0_q;
    bits_l1_d     = bits_l1_q;
    bits_l2_d     = bits_l2_q;
    bits_l3_d     = bits_l3_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        mpt_pkg::REG_LEVEL_COUNT: level_count_d = cfg_data_i[mpt_pkg::LVL_CNT_W-1:0];
        mpt_pkg::REG_BITS_L0:     bits_l0_d     = cfg_data_i;
        mpt_pkg::REG_BITS_L1:     bits_l1_d     = cfg_data_i;
        mpt_pkg::REG_BITS_L2:     bits_l2_d     = cfg_data_i;
        mpt_pkg::REG_BITS_L3:     bits_l3_d     = cfg_data_i;
        default: ;
      endcase
    end
  end

  // a write to a register in the list wipes the table
  logic cfg_hit;
  assign cfg_hit = cfg_write && (cfg_index_i <= mpt_pkg::REG_BITS_L3);

  // walk sequencer
  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    next_free_d    = next_free_q;
    insert_count_d = insert_count_q;
    lvl_d          = lvl_q;
    rsp_valid_d    = rsp_valid_q;
    aligned_d      = aligned_q;
    base_d         = base_q;
    slot_d         = slot_q;
    insert_d       = insert_q;
    frame_d        = frame_q;
    status_d       = status_q;
    frame_out_d    = frame_out_q;
    rsp_d          = rsp_q;
    mem_we         = 1'b0;
    mem_waddr      = slot_q[AW-1:0];
    mem_wdata      = '0;
    mem_re         = 1'b0;

    if (rsp_valid_q && !rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_q;
        next_free_d = NF_W'(17'(1) << mpt_pkg::eff_bits(bits_l0_q));
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_WORDS - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_accept) begin
          insert_d    = (req_i.func == mpt_pkg::FUNC_INSERT);
          aligned_d   = mpt_pkg::ALIGN_W'({32'b0, req_i.logical_address} << ALIGN_SH);
          frame_d     = req_i.frame[FBE-1:0];
          base_d      = '0;
          lvl_d       = '0;
          status_d    = (req_i.func == mpt_pkg::FUNC_INSERT) ? mpt_pkg::STATUS_FULL
                                                             : mpt_pkg::STATUS_MISS;
          frame_out_d = '0;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        // slot past the end of the store ends the walk with the initial status
        if (su_flags.slot_ok) begin
          mem_re    = 1'b1;
          slot_d    = su_slot;
          aligned_d = su_aligned;
          state_d   = ST_CHECK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CHECK: begin
        if (lvl_q == last_lvl) begin
          if (insert_q) begin
            mem_we         = 1'b1;
            mem_wdata      = {1'b1, PW'(frame_q)};
            insert_count_d = insert_count_q + mpt_pkg::COUNT_W'(1);
            status_d       = mpt_pkg::STATUS_INSERTED;
          end else if (rd_q[PW]) begin
            status_d    = mpt_pkg::STATUS_HIT;
            frame_out_d = pay_ext[mpt_pkg::FRAME_W-1:0];
          end
          state_d = ST_DONE;
        end else if (rd_q[PW]) begin
          base_d  = rd_q[AW-1:0];
          lvl_d   = lvl_next;
          state_d = ST_READ;
        end else if (!insert_q || !su_flags.alloc_ok) begin
          // lookup miss, or store exhausted on insert
          state_d = ST_DONE;
        end else begin
          // link a fresh zeroed child node
          mem_we      = 1'b1;
          mem_wdata   = {1'b1, PW'(next_free_q[AW-1:0])};
          base_d      = next_free_q[AW-1:0];
          next_free_d = su_next_free;
          lvl_d       = lvl_next;
          state_d     = ST_READ;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp_d.status           = status_q;
          rsp_d.frame_out        = frame_out_q;
          rsp_d.frames_allocated = insert_count_q;
          rsp_valid_d            = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        clr_d   = '0;
        state_d = ST_CLEAR;
      end
    endcase

    // a write to a listed register restarts the sweep; only taken while idle or sweeping
    if (cfg_hit) begin
      clr_d   = '0;
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      level_count_q  <= mpt_pkg::LEVEL_COUNT_RST;
      bits_l0_q      <= mpt_pkg::BITS_L0_RST;
      bits_l1_q      <= mpt_pkg::BITS_L1_RST;
      bits_l2_q      <= mpt_pkg::BITS_L2_RST;
      bits_l3_q      <= mpt_pkg::BITS_L3_RST;
      clr_q          <= '0;
      next_free_q    <= NF_W'(17'(1) << mpt_pkg::eff_bits(mpt_pkg::BITS_L0_RST));
      insert_count_q <= '0;
      lvl_q          <= '0;
      rsp_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      level_count_q  <= level_count_d;
      bits_l0_q      <= bits_l0_d;
      bits_l1_q      <= bits_l1_d;
      bits_l2_q      <= bits_l2_d;
      bits_l3_q      <= bits_l3_d;
      clr_q          <= clr_d;
      next_free_q    <= next_free_d;
      insert_count_q <= insert_count_d;
      lvl_q          <= lvl_d;
      rsp_valid_q    <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aligned_q   <= aligned_d;
    base_q      <= base_d;
    slot_q      <= slot_d;
    insert_q    <= insert_d;
    frame_q     <= frame_d;
    status_q    <= status_d;
    frame_out_q <= frame_out_d;
    rsp_q       <= rsp_d;
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[su_slot[AW-1:0]];
    end
  end

  // the bump pointer only moves forward during a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |=> (next_free_q >= $past(next_free_q)))
    else $error("next_free moved backward during a walk");

  // insert count changes only on a leaf write of an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (insert_count_q != $past(insert_count_q)) |->
      $past(state_q == ST_CHECK && insert_q && lvl_q == last_lvl))
    else $error("insert count changed outside a leaf insert");

  // a result is posted only from the done step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result posted outside the done step");

  // table writes happen only in the sweep or the check step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_CHECK))
    else $error("table written outside sweep or check");

endmodule

`default_nettype wire

/* sv/mpt_step_unit.sv */
`default_nettype none

// shared per-level unit: index extract, slot add and range check, allocation check
module mpt_step_unit #(
  parameter  int TABLE_WORDS = mpt_pkg::TABLE_WORDS_DEF,
  localparam int AW          = $clog2(TABLE_WORDS),
  localparam int SW          = ((AW > mpt_pkg::IDX_W) ? AW : mpt_pkg::IDX_W) + 1,
  localparam int NF_W        = ((AW > mpt_pkg::IDX_W + 1) ? AW : mpt_pkg::IDX_W + 1) + 1
) (
  input  wire logic [mpt_pkg::ALIGN_W-1:0]    aligned_i,
  input  wire logic [mpt_pkg::LVL_BITS_W-1:0] bits_i,
  input  wire logic [AW-1:0]                  base_i,
  input  wire logic [NF_W-1:0]                next_free_i,
  input  wire logic [mpt_pkg::LVL_BITS_W-1:0] child_bits_i,
  output logic      [mpt_pkg::ALIGN_W-1:0]    aligned_o,
  output logic      [SW-1:0]                  slot_o,
  output logic      [NF_W-1:0]                next_free_o,
  output mpt_pkg::step_flags_t                flags_o
);

  logic [mpt_pkg::IDX_W-1:0]   top;
  logic [mpt_pkg::IDX_W-1:0]   idx;
  logic [mpt_pkg::IDX_W:0]     node_size;
  logic [NF_W-1:0]             nf_sum;

  assign top = aligned_i[mpt_pkg::ALIGN_W-1 -: mpt_pkg::IDX_W];
  assign idx = top >> (mpt_pkg::LVL_BITS_W'(mpt_pkg::MAX_IDX_BITS) - bits_i);
  assign aligned_o = aligned_i << bits_i;

  assign slot_o = SW'(base_i) + SW'(idx);

  assign node_size = (mpt_pkg::IDX_W + 1)'(1) << child_bits_i;
  assign nf_sum    = next_free_i + NF_W'(node_size);
  assign next_free_o = nf_sum;

  assign flags_o.slot_ok  = (slot_o < SW'(TABLE_WORDS));
  assign flags_o.alloc_ok = (nf_sum <= NF_W'(TABLE_WORDS));

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;

  // clock period in time units, run bounds in cycles
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_CYCLES = 4000000;
  localparam int POOL_DEPTH     = 48;
  localparam int MAX_SHOWN      = 10;
  localparam int DIR_ROWS       = 20;

  // short names for the directed table
  localparam mpt_pkg::func_e   OP_LOOKUP = mpt_pkg::FUNC_LOOKUP;
  localparam mpt_pkg::func_e   OP_INSERT = mpt_pkg::FUNC_INSERT;
  localparam mpt_pkg::status_e ST_MISS   = mpt_pkg::STATUS_MISS;
  localparam mpt_pkg::status_e ST_HIT    = mpt_pkg::STATUS_HIT;
  localparam mpt_pkg::status_e ST_INS    = mpt_pkg::STATUS_INSERTED;

  // table entry layout: valid on top, child base or frame below
  localparam logic [31:0] ENTRY_VALID = 32'h8000_0000;

  // one row of the directed part; typed rows carry their expected response
  typedef struct packed {
    mpt_pkg::func_e                      op;
    logic [mpt_pkg::ADDR_W-1:0]          addr;
    logic [mpt_pkg::FRAME_W-1:0]         frame;
    logic                                typed;
    mpt_pkg::status_e                    st;
    logic [mpt_pkg::FRAME_W-1:0]         frame_out;
    logic [mpt_pkg::COUNT_W-1:0]         count;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_stall_o;
  mpt_pkg::req_t req_i;
  logic rsp_valid_o;
  logic rsp_stall_i;
  mpt_pkg::rsp_t rsp_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [mpt_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [mpt_pkg::CFG_DATA_W-1:0] cfg_data_i;

  multilevel_page_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow copy of the table walker state
  logic [mpt_pkg::LVL_CNT_W-1:0]  level_count_q;
  logic [mpt_pkg::LVL_BITS_W-1:0] level_bits_q [4];
  logic [31:0]                    table_q [int unsigned];
  int unsigned                    next_free_q;
  logic [mpt_pkg::COUNT_W-1:0]    insert_total_q;

  // responses still owed by the block, oldest first
  mpt_pkg::rsp_t walk_results_q [$];
  // addresses inserted under the current settings, reused to get hits
  logic [mpt_pkg::ADDR_W-1:0] addr_pool [$];

  dir_row_t dir_rows [DIR_ROWS];

  int error_count;
  int shown_count;
  bit send_idle_on;
  bit recv_idle_on;
  bit hold_request;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // level count out of range: zero reads as one, anything above the cap saturates
  function automatic int unsigned clamp_levels(input logic [mpt_pkg::LVL_CNT_W-1:0] v);
    int unsigned n;
    n = v;
    if (n < 1) n = 1;
    if (n > mpt_pkg::MAX_LEVELS_DEF) n = mpt_pkg::MAX_LEVELS_DEF;
    return n;
  endfunction

  // level width out of range: zero reads as one, above sixteen saturates
  function automatic int unsigned clamp_bits(input int unsigned level);
    int unsigned b;
    b = level_bits_q[level & 3];
    if (b < 1) b = 1;
    if (b > mpt_pkg::MAX_IDX_BITS) b = mpt_pkg::MAX_IDX_BITS;
    return b;
  endfunction

  // walk the shadow table for one request, allocating on insert
  function automatic mpt_pkg::rsp_t walk_table(input mpt_pkg::req_t r);
    logic [mpt_pkg::ALIGN_W-1:0] aligned;
    int unsigned lc, b, cum, base, idx, slot, size, i;
    logic [31:0] entry;
    bit ins;
    mpt_pkg::rsp_t res;
    ins = (r.func == mpt_pkg::FUNC_INSERT);
    // address parked at the top so fields running past bit 0 read zeros
    aligned = {r.logical_address, 32'h0};
    lc = clamp_levels(level_count_q);
    cum = 0;
    base = 0;
    res.status = ins ? mpt_pkg::STATUS_FULL : mpt_pkg::STATUS_MISS;
    res.frame_out = '0;
    for (i = 0; i < lc; i++) begin
      b = clamp_bits(i);
      cum += b;
      idx = int'((aligned >> (mpt_pkg::ALIGN_W - cum)) & ((64'd1 << b) - 64'd1));
      slot = base + idx;
      if (slot >= mpt_pkg::TABLE_WORDS_DEF) break;
      entry = table_q.exists(slot) ? table_q[slot] : 32'h0;
      if (i + 1 == lc) begin
        // leaf level: insert overwrites even a valid leaf and counts again
        if (ins) begin
          table_q[slot] = ENTRY_VALID | 32'(r.frame);
          insert_total_q++;
          res.status = mpt_pkg::STATUS_INSERTED;
        end else if (entry[31]) begin
          res.status = mpt_pkg::STATUS_HIT;
          res.frame_out = entry[mpt_pkg::FRAME_W-1:0];
        end
        break;
      end
      if (entry[31]) begin
        base = entry[30:0];
      end else begin
        if (!ins) break;
        size = 1 << clamp_bits(i + 1);
        // store exhausted: children already linked stay linked
        if (next_free_q + size > mpt_pkg::TABLE_WORDS_DEF) break;
        table_q[slot] = ENTRY_VALID | next_free_q;
        base = next_free_q;
        next_free_q += size;
      end
    end
    res.frames_allocated = insert_total_q;
    return res;
  endfunction

  // random request: mostly reuse of inserted addresses, the rest noise
  function automatic mpt_pkg::req_t draw_request();
    mpt_pkg::req_t r;
    int unsigned pick;
    logic [mpt_pkg::ADDR_W-1:0] noise, seen;
    pick = $urandom_range(99);
    noise = $urandom;
    r.func = ($urandom_range(1) == 1) ? mpt_pkg::FUNC_INSERT : mpt_pkg::FUNC_LOOKUP;
    r.frame = mpt_pkg::FRAME_W'($urandom);
    if (addr_pool.size() == 0 || pick < 30) begin
      r.logical_address = noise;
    end else begin
      seen = addr_pool[$urandom_range(addr_pool.size() - 1)];
      if (pick < 70) begin
        r.logical_address = seen;
      end else if (pick < 85) begin
        // same upper path, low bits stirred
        r.logical_address = seen ^ (noise & 32'h0000_FFFF);
      end else begin
        // shares the top level only
        r.logical_address = {seen[31:24], noise[23:0]};
      end
    end
    if (r.func == mpt_pkg::FUNC_INSERT) begin
      addr_pool.push_back(r.logical_address);
      if (addr_pool.size() > POOL_DEPTH) void'(addr_pool.pop_front());
    end
    return r;
  endfunction

  // offer one request, called and returning at a falling edge
  task automatic push_request(input mpt_pkg::req_t r, input bit typed,
                              input mpt_pkg::rsp_t typed_rsp);
    mpt_pkg::rsp_t predicted;
    while (send_idle_on && $urandom_range(99) < 25) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    // request taken at this edge
    predicted = walk_table(r);
    walk_results_q.push_back(typed ? typed_rsp : predicted);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n);
    repeat (n) push_request(draw_request(), 1'b0, '0);
  endtask

  // stop offering and wait until every owed response is back
  task automatic drain_results();
    int n;
    n = 0;
    req_valid_i <= 1'b0;
    while (walk_results_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk_i);
      n++;
    end
    if (walk_results_q.size() != 0) begin
      $display("responses never returned: %0d", walk_results_q.size());
      error_count += walk_results_q.size();
      walk_results_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write; leaves valid high so writes can follow back to back
  task automatic write_register(input mpt_pkg::cfg_reg_e sel,
                                input logic [mpt_pkg::CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (sel == mpt_pkg::REG_LEVEL_COUNT) begin
      level_count_q = value[mpt_pkg::LVL_CNT_W-1:0];
    end else begin
      level_bits_q[int'(sel) - int'(mpt_pkg::REG_BITS_L0)] = value;
    end
    // any write clears the table; the insert count survives
    table_q.delete();
    next_free_q = 1 << clamp_bits(0);
    addr_pool.delete();
    @(negedge clk_i);
  endtask

  task automatic check_response(input mpt_pkg::rsp_t got);
    mpt_pkg::rsp_t want;
    if (walk_results_q.size() == 0) begin
      error_count++;
      if (shown_count < MAX_SHOWN) begin
        $display("unexpected response: status %0d frame %05h count %0d",
                 got.status, got.frame_out, got.frames_allocated);
      end
      shown_count++;
    end else begin
      want = walk_results_q.pop_front();
      if (got.status !== want.status || got.frame_out !== want.frame_out ||
          got.frames_allocated !== want.frames_allocated) begin
        error_count++;
        if (shown_count < MAX_SHOWN) begin
          $display("mismatch: status exp %0d got %0d, frame exp %05h got %05h,",
                   want.status, got.status, want.frame_out, got.frame_out,
                   " count exp %0d got %0d",
                   want.frames_allocated, got.frames_allocated);
        end
        shown_count++;
      end
    end
  endtask

  // response taken at every edge with valid high and no stall
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      check_response(rsp_o);
    end
  end

  // receiver: random stalls, plus one long hold-off on request from the sender
  initial begin
    rsp_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      rsp_stall_i <= recv_idle_on && ($urandom_range(99) < 25);
    end
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("run limit reached");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mpt_pkg::req_t req;
    mpt_pkg::rsp_t want;
    int k;

    // directed part under reset settings: two levels of eight bits
    dir_rows = '{
      // empty table
      '{OP_LOOKUP, 32'h0000_0000, 20'h00000, 1'b1, ST_MISS, 20'h00000, 32'd0},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, ST_MISS, 20'h00000, 32'd0},
      // first insert allocates a child and sets the leaf
      '{OP_INSERT, 32'h1234_5678, 20'hABCDE, 1'b1, ST_INS,  20'h00000, 32'd1},
      '{OP_LOOKUP, 32'h1234_5678, 20'h00000, 1'b1, ST_HIT,  20'hABCDE, 32'd1},
      // child present, leaf absent
      '{OP_LOOKUP, 32'h1200_0000, 20'h00000, 1'b1, ST_MISS, 20'h00000, 32'd1},
      // bits below the index fields do not matter
      '{OP_LOOKUP, 32'h1234_FFFF, 20'h00000, 1'b1, ST_HIT,  20'hABCDE, 32'd1},
      // overwrite of a valid leaf counts again
      '{OP_INSERT, 32'h1234_5678, 20'h00001, 1'b1, ST_INS,  20'h00000, 32'd2},
      '{OP_LOOKUP, 32'h1234_0000, 20'h00000, 1'b1, ST_HIT,  20'h00001, 32'd2},
      // field extremes
      '{OP_INSERT, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, ST_INS,  20'h00000, 32'd3},
      '{OP_LOOKUP, 32'hFFFF_0000, 20'h00000, 1'b1, ST_HIT,  20'hFFFFF, 32'd3},
      '{OP_INSERT, 32'h0000_0000, 20'h00000, 1'b1, ST_INS,  20'h00000, 32'd4},
      '{OP_LOOKUP, 32'h0000_0000, 20'h00000, 1'b1, ST_HIT,  20'h00000, 32'd4},
      '{OP_LOOKUP, 32'h8000_0000, 20'h00000, 1'b1, ST_MISS, 20'h00000, 32'd4},
      '{OP_INSERT, 32'h8000_0000, 20'h80000, 1'b1, ST_INS,  20'h00000, 32'd5},
      '{OP_LOOKUP, 32'h80FF_1234, 20'h00000, 1'b1, ST_MISS, 20'h00000, 32'd5},
      '{OP_INSERT, 32'h7FFF_FFFF, 20'h7FFFF, 1'b1, ST_INS,  20'h00000, 32'd6},
      // frame field ignored on lookup
      '{OP_LOOKUP, 32'h7FFF_0000, 20'hFFFFF, 1'b1, ST_HIT,  20'h7FFFF, 32'd6},
      // left to the predictor
      '{OP_INSERT, 32'hA5A5_A5A5, 20'h5A5A5, 1'b0, ST_MISS, 20'h00000, 32'd0},
      '{OP_LOOKUP, 32'hA5A5_0000, 20'h00000, 1'b0, ST_MISS, 20'h00000, 32'd0},
      '{OP_LOOKUP, 32'h5A5A_5A5A, 20'h00000, 1'b0, ST_MISS, 20'h00000, 32'd0}
    };

    error_count  = 0;
    shown_count  = 0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    hold_request = 1'b0;

    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mpt_pkg::REG_LEVEL_COUNT;
    cfg_data_i  = '0;

    // shadow state after reset
    level_count_q   = mpt_pkg::LEVEL_COUNT_RST;
    level_bits_q[0] = mpt_pkg::BITS_L0_RST;
    level_bits_q[1] = mpt_pkg::BITS_L1_RST;
    level_bits_q[2] = mpt_pkg::BITS_L2_RST;
    level_bits_q[3] = mpt_pkg::BITS_L3_RST;
    insert_total_q  = '0;
    next_free_q     = 1 << clamp_bits(0);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // the table sweep after reset shows up as a stalled first request
    for (k = 0; k < DIR_ROWS; k++) begin
      req.func            = dir_rows[k].op;
      req.logical_address = dir_rows[k].addr;
      req.frame           = dir_rows[k].frame;
      want.status           = dir_rows[k].st;
      want.frame_out        = dir_rows[k].frame_out;
      want.frames_allocated = dir_rows[k].count;
      push_request(req, dir_rows[k].typed, want);
    end

    run_random(90);
    // sender pause until everything is back
    drain_results();
    run_random(80);

    // two levels, 8 + 12: only fifteen children fit, so the store runs out
    drain_results();
    write_register(mpt_pkg::REG_BITS_L1, 5'd12);
    cfg_valid_i <= 1'b0;
    // let the sweep finish, then a long receiver hold-off while requests keep coming
    run_random(20);
    hold_request = 1'b1;
    run_random(100);

    // three levels, 8 + 12 + 13: fields run past address bit 0; no idling here
    drain_results();
    write_register(mpt_pkg::REG_BITS_L2, 5'd13);
    write_register(mpt_pkg::REG_LEVEL_COUNT, 3'd3);
    cfg_valid_i <= 1'b0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    run_random(100);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // level count above the cap reads as four, level 3 width zero reads as one
    drain_results();
    write_register(mpt_pkg::REG_LEVEL_COUNT, 3'd7);
    write_register(mpt_pkg::REG_BITS_L3, 5'd0);
    cfg_valid_i <= 1'b0;
    run_random(100);

    // level 0 width saturates at sixteen: the root fills the store, inserts fail
    drain_results();
    write_register(mpt_pkg::REG_BITS_L0, 5'd31);
    cfg_valid_i <= 1'b0;
    run_random(30);

    // level count zero reads as one: single level of one bit
    drain_results();
    write_register(mpt_pkg::REG_BITS_L0, 5'd1);
    write_register(mpt_pkg::REG_LEVEL_COUNT, 3'd0);
    cfg_valid_i <= 1'b0;
    run_random(60);

    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
